/* rtl/tli_pkg.sv */
`timescale 1ns / 1ps
package tli_pkg;

	// Item kinds on the command channel
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// Program characters that carry a command
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	typedef enum logic [2:0] {
		C_INC, C_DEC, C_LEFT, C_RIGHT, C_OUT, C_IN, C_OPEN, C_CLOSE
	} cmd_code_t;

	typedef enum logic [2:0] {
		M_LOADING, M_IDLE, M_FAIL_BRACKET, M_FAIL_SIZE,
		M_RUNNING, M_HALT_DONE, M_HALT_INPUT, M_HALT_PTR
	} run_mode_t;

	typedef enum logic [2:0] {
		S_OK, S_FINISHED, S_UNMATCHED, S_TOO_BIG, S_INPUT, S_POINTER, S_NOT_LOADED
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_POP, ST_PAIR, ST_EXEC, ST_CLEAR, ST_POST
	} seq_state_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] program_char;
		logic       is_last;
	} cmd_item_t;

	typedef struct packed {
		logic       out_valid;
		logic [7:0] out_byte;
		status_t    status;
	} rsp_item_t;

	typedef struct packed {
		logic      hit;
		cmd_code_t code;
	} decode_t;

	// Map a program character to its command code
	function automatic decode_t decode_char(input logic [7:0] ch);
		decode_t d;
		d.hit  = 1'b1;
		d.code = C_INC;
		case (ch)
			CH_PLUS:   d.code = C_INC;
			CH_MINUS:  d.code = C_DEC;
			CH_LT:     d.code = C_LEFT;
			CH_GT:     d.code = C_RIGHT;
			CH_DOT:    d.code = C_OUT;
			CH_COMMA:  d.code = C_IN;
			CH_LBRACK: d.code = C_OPEN;
			CH_RBRACK: d.code = C_CLOSE;
			default:   d.hit  = 1'b0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/tli_ram.sv */
`timescale 1ns / 1ps
module tli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry with a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/tli_out_stage.sv */
`timescale 1ns / 1ps
module tli_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              post_valid,
	output logic              post_ready,
	input  tli_pkg::rsp_item_t post_item,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output tli_pkg::rsp_item_t rsp
);
	import tli_pkg::*;

	logic      full_q;
	rsp_item_t data_q;

	// Take a new item when empty or when the held one leaves this cycle
	assign post_ready = !full_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (post_valid && post_ready) begin
			full_q <= 1'b1;
		end else if (!rsp_stall) begin
			full_q <= 1'b0;
		end
	end

	// Hold the payload until taken
	always_ff @(posedge clk) begin
		if (post_valid && post_ready) begin
			data_q <= post_item;
		end
	end

	assign rsp_valid = full_q;
	assign rsp       = data_q;

endmodule

/* rtl/tli_core.sv */
`timescale 1ns / 1ps
module tli_core #(
	parameter int PROG_DEPTH = 4096,
	parameter int TAPE_DEPTH = 32768,
	parameter int CELL_WIDTH = 8,
	parameter int NEST_DEPTH = 256,
	localparam int PW = $clog2(PROG_DEPTH),
	localparam int TW = $clog2(TAPE_DEPTH),
	localparam int NW = $clog2(NEST_DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  tli_pkg::cmd_item_t    cmd,
	output logic                  post_valid,
	input  logic                  post_ready,
	output tli_pkg::rsp_item_t    post_item,
	output logic                  prog_we,
	output logic [PW-1:0]         prog_waddr,
	output logic [PW+2:0]         prog_wdata,
	output logic [PW-1:0]         prog_raddr,
	input  logic [PW+2:0]         prog_rdata,
	output logic                  stk_we,
	output logic [NW-1:0]         stk_waddr,
	output logic [PW-1:0]         stk_wdata,
	output logic [NW-1:0]         stk_raddr,
	input  logic [PW-1:0]         stk_rdata,
	output logic                  tape_we,
	output logic [TW-1:0]         tape_waddr,
	output logic [CELL_WIDTH-1:0] tape_wdata,
	output logic [TW-1:0]         tape_raddr,
	input  logic [CELL_WIDTH-1:0] tape_rdata
);
	import tli_pkg::*;

	localparam logic [PW:0]   PROG_FULL = (PW+1)'(PROG_DEPTH);
	localparam logic [NW:0]   NEST_FULL = (NW+1)'(NEST_DEPTH);
	localparam logic [TW-1:0] TAPE_LAST = TW'(TAPE_DEPTH - 1);

	seq_state_t state_q, state_d;
	run_mode_t  mode_q, mode_d;
	logic [PW:0]   len_q, len_d;
	logic [NW:0]   depth_q, depth_d;
	logic [PW:0]   pc_q, pc_d;
	logic [TW-1:0] ptr_q, ptr_d;
	logic [TW-1:0] clr_q, clr_d;
	logic [PW-1:0] cl_q, cl_d;
	logic [PW-1:0] open_q, open_d;
	logic          start_q, start_d;
	rsp_item_t     res_q, res_now;

	logic accept;
	logic fin_now, to_pop, to_exec, to_clear;

	// Load evaluation signals
	logic          load_mode;
	logic [PW:0]   eff_len;
	logic [NW:0]   eff_depth;
	decode_t       dec;
	status_t       ld_err;
	logic          ld_push, ld_pop, ld_store;
	logic [PW:0]   ld_len;
	logic [NW:0]   ld_depth;

	// Execute evaluation signals
	cmd_code_t         ex_code;
	logic [PW-1:0]     ex_jump;
	logic              cell_zero;
	logic [PW:0]       pc_inc, pc_jump;

	assign accept    = cmd_valid && (state_q == ST_IDLE);
	assign cmd_stall = (state_q != ST_IDLE);

	// Evaluate one load character against the bracket stack
	always_comb begin
		load_mode = mode_q inside {M_LOADING, M_FAIL_BRACKET, M_FAIL_SIZE};
		eff_len   = load_mode ? len_q : '0;
		eff_depth = load_mode ? depth_q : '0;
		dec       = decode_char(cmd.program_char);
		ld_err    = S_OK;
		ld_push   = 1'b0;
		ld_pop    = 1'b0;
		ld_store  = 1'b0;
		ld_len    = eff_len;
		ld_depth  = eff_depth;
		if (mode_q == M_FAIL_BRACKET) begin
			ld_err = S_UNMATCHED;
		end else if (mode_q == M_FAIL_SIZE) begin
			ld_err = S_TOO_BIG;
		end else if (dec.hit) begin
			if (eff_len == PROG_FULL) begin
				ld_err = S_TOO_BIG;
			end else if (dec.code == C_OPEN) begin
				if (eff_depth == NEST_FULL) begin
					ld_err = S_TOO_BIG;
				end else begin
					ld_push  = 1'b1;
					ld_depth = eff_depth + (NW+1)'(1);
				end
			end else if (dec.code == C_CLOSE) begin
				if (eff_depth == '0) begin
					ld_err = S_UNMATCHED;
				end else begin
					ld_pop   = 1'b1;
					ld_depth = eff_depth - (NW+1)'(1);
				end
			end
			if (ld_err == S_OK) begin
				ld_store = (dec.code != C_CLOSE);
				ld_len   = eff_len + (PW+1)'(1);
			end
		end
		if (ld_err == S_OK && cmd.is_last && ld_depth != '0) begin
			ld_err = S_UNMATCHED;
		end
	end

	// Decode the fetched command
	always_comb begin
		ex_code   = cmd_code_t'(prog_rdata[PW+2:PW]);
		ex_jump   = prog_rdata[PW-1:0];
		cell_zero = (tape_rdata == '0);
		pc_inc    = pc_q + (PW+1)'(1);
		pc_jump   = {1'b0, ex_jump} + (PW+1)'(1);
	end

	// Memory read ports
	always_comb begin
		prog_raddr = pc_q[PW-1:0];
		tape_raddr = ptr_q;
		stk_raddr  = NW'(eff_depth - (NW+1)'(1));
	end

	// Register updates, memory writes and the result of this cycle
	always_comb begin
		mode_d     = mode_q;
		len_d      = len_q;
		depth_d    = depth_q;
		pc_d       = pc_q;
		ptr_d      = ptr_q;
		clr_d      = clr_q;
		cl_d       = cl_q;
		open_d     = open_q;
		start_d    = start_q;
		res_now    = res_q;
		fin_now    = 1'b0;
		to_pop     = 1'b0;
		to_exec    = 1'b0;
		to_clear   = 1'b0;
		prog_we    = 1'b0;
		prog_waddr = eff_len[PW-1:0];
		prog_wdata = {dec.code, {PW{1'b0}}};
		stk_we     = 1'b0;
		stk_waddr  = eff_depth[NW-1:0];
		stk_wdata  = eff_len[PW-1:0];
		tape_we    = 1'b0;
		tape_waddr = ptr_q;
		tape_wdata = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					clr_d = '0;
					res_now = '{out_valid: 1'b0, out_byte: 8'h00, status: S_OK};
					if (cmd.opcode == OP_LOAD) begin
						res_now.status = ld_err;
						len_d   = ld_len;
						depth_d = ld_depth;
						cl_d    = eff_len[PW-1:0];
						start_d = cmd.is_last;
						prog_we = ld_store;
						stk_we  = ld_push;
						if (ld_err != S_OK) begin
							if (cmd.is_last) begin
								mode_d = M_IDLE;
							end else if (ld_err == S_UNMATCHED) begin
								mode_d = M_FAIL_BRACKET;
							end else begin
								mode_d = M_FAIL_SIZE;
							end
							fin_now = 1'b1;
						end else if (ld_pop) begin
							mode_d = M_LOADING;
							to_pop = 1'b1;
						end else if (cmd.is_last) begin
							mode_d   = M_RUNNING;
							pc_d     = '0;
							ptr_d    = '0;
							to_clear = 1'b1;
						end else begin
							mode_d  = M_LOADING;
							fin_now = 1'b1;
						end
						if (ld_pop && ld_err == S_OK && cmd.is_last) begin
							mode_d = M_RUNNING;
							pc_d   = '0;
							ptr_d  = '0;
						end
					end else begin
						case (mode_q)
							M_HALT_DONE: begin
								res_now.status = S_FINISHED;
								fin_now = 1'b1;
							end
							M_HALT_INPUT: begin
								res_now.status = S_INPUT;
								fin_now = 1'b1;
							end
							M_HALT_PTR: begin
								res_now.status = S_POINTER;
								fin_now = 1'b1;
							end
							M_RUNNING: begin
								if (pc_q >= len_q) begin
									mode_d = M_HALT_DONE;
									res_now.status = S_FINISHED;
									fin_now = 1'b1;
								end else begin
									to_exec = 1'b1;
								end
							end
							default: begin
								res_now.status = S_NOT_LOADED;
								fin_now = 1'b1;
							end
						endcase
					end
				end
			end
			ST_POP: begin
				// Close bracket points back at its open bracket
				prog_we    = 1'b1;
				prog_waddr = cl_q;
				prog_wdata = {C_CLOSE, stk_rdata};
				open_d     = stk_rdata;
			end
			ST_PAIR: begin
				// Open bracket points forward at its close bracket
				prog_we    = 1'b1;
				prog_waddr = open_q;
				prog_wdata = {C_OPEN, cl_q};
				if (start_q) begin
					to_clear = 1'b1;
				end else begin
					fin_now = 1'b1;
				end
			end
			ST_EXEC: begin
				res_now = '{out_valid: 1'b0, out_byte: 8'h00, status: S_OK};
				fin_now = 1'b1;
				pc_d    = pc_inc;
				case (ex_code)
					C_INC: begin
						tape_we    = 1'b1;
						tape_wdata = tape_rdata + CELL_WIDTH'(1);
					end
					C_DEC: begin
						tape_we    = 1'b1;
						tape_wdata = tape_rdata - CELL_WIDTH'(1);
					end
					C_LEFT: begin
						if (ptr_q == '0) begin
							mode_d = M_HALT_PTR;
							pc_d   = pc_q;
							res_now.status = S_POINTER;
						end else begin
							ptr_d = ptr_q - TW'(1);
						end
					end
					C_RIGHT: begin
						if (ptr_q == TAPE_LAST) begin
							mode_d = M_HALT_PTR;
							pc_d   = pc_q;
							res_now.status = S_POINTER;
						end else begin
							ptr_d = ptr_q + TW'(1);
						end
					end
					C_OUT: begin
						res_now.out_valid = 1'b1;
						res_now.out_byte  = tape_rdata[7:0];
					end
					C_IN: begin
						mode_d = M_HALT_INPUT;
						pc_d   = pc_q;
						res_now.status = S_INPUT;
					end
					C_OPEN: begin
						if (cell_zero) begin
							pc_d = pc_jump;
						end
					end
					C_CLOSE: begin
						if (!cell_zero) begin
							pc_d = pc_jump;
						end
					end
					default: begin
						pc_d = pc_inc;
					end
				endcase
			end
			ST_CLEAR: begin
				// Sweep the tape to zero, one cell per cycle
				tape_we    = 1'b1;
				tape_waddr = clr_q;
				tape_wdata = '0;
				clr_d      = clr_q + TW'(1);
				fin_now    = (clr_q == TAPE_LAST);
			end
			ST_POST: begin
				fin_now = 1'b1;
			end
			default: begin
				fin_now = 1'b0;
			end
		endcase
	end

	assign post_valid = fin_now;
	assign post_item  = res_now;

	// Next state
	always_comb begin
		state_d = state_q;
		if (fin_now) begin
			state_d = post_ready ? ST_IDLE : ST_POST;
		end else if (to_pop) begin
			state_d = ST_POP;
		end else if (state_q == ST_POP) begin
			state_d = ST_PAIR;
		end else if (to_clear) begin
			state_d = ST_CLEAR;
		end else if (to_exec) begin
			state_d = ST_EXEC;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q  <= M_LOADING;
			len_q   <= '0;
			depth_q <= '0;
			pc_q    <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			len_q   <= len_d;
			depth_q <= depth_d;
			pc_q    <= pc_d;
			ptr_q   <= ptr_d;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		clr_q   <= clr_d;
		cl_q    <= cl_d;
		open_q  <= open_d;
		start_q <= start_d;
		if (state_q != ST_POST) begin
			res_q <= res_now;
		end
	end

	// Counters stay within the storage they index
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= PROG_FULL && depth_q <= NEST_FULL)
		else $error("program length or nesting depth out of range");

	// A command executes only inside a running program
	a_exec_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> mode_q == M_RUNNING && pc_q < len_q)
		else $error("command executed outside a running program");

	// The tape sweep starts a program from its first cell and command
	a_clear_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> mode_q == M_RUNNING && pc_q == '0 && ptr_q == '0)
		else $error("tape sweep outside program start");

	// A refused result is held unchanged for the next attempt
	a_post_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin_now && !post_ready |=> state_q == ST_POST && res_q == $past(res_now))
		else $error("refused result not held");

endmodule

/* rtl/tape_language_interpreter_top.sv */
`timescale 1ns / 1ps
// Tape language interpreter. Load items (opcode 0) deliver a program one character at a
// time; the eight commands are kept and brackets are paired on the fly, and the item
// marked is_last closes the program. A cleanly loaded program is followed by a sweep that
// zeroes the tape, one cell per cycle, during which no item is taken; the load result is
// delivered after the sweep. Step items (opcode 1) then execute one command each. A
// closing bracket also passes through ST_POP, which reads the bracket stack and writes
// the close, and ST_PAIR, which writes the open bracket, since the program memory has a
// single write port. A step that executes a command first does the synchronous read of
// program and tape memories, then executes and writes back the cell. One result item
// per item; the result register lets the next item in while a result still waits to be
// taken.
module tape_language_interpreter_top #(
	parameter int PROG_DEPTH = 4096,
	parameter int TAPE_DEPTH = 32768,
	parameter int CELL_WIDTH = 8,
	parameter int NEST_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  tli_pkg::cmd_item_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tli_pkg::rsp_item_t rsp
);
	import tli_pkg::*;

	localparam int PW = $clog2(PROG_DEPTH);
	localparam int TW = $clog2(TAPE_DEPTH);
	localparam int NW = $clog2(NEST_DEPTH);

	logic          post_valid, post_ready;
	rsp_item_t     post_item;

	logic          prog_we;
	logic [PW-1:0] prog_waddr, prog_raddr;
	logic [PW+2:0] prog_wdata, prog_rdata;

	logic          stk_we;
	logic [NW-1:0] stk_waddr, stk_raddr;
	logic [PW-1:0] stk_wdata, stk_rdata;

	logic                  tape_we;
	logic [TW-1:0]         tape_waddr, tape_raddr;
	logic [CELL_WIDTH-1:0] tape_wdata, tape_rdata;

	// Sequencer for loading and stepping
	tli_core #(
		.PROG_DEPTH(PROG_DEPTH),
		.TAPE_DEPTH(TAPE_DEPTH),
		.CELL_WIDTH(CELL_WIDTH),
		.NEST_DEPTH(NEST_DEPTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.post_valid (post_valid),
		.post_ready (post_ready),
		.post_item  (post_item),
		.prog_we    (prog_we),
		.prog_waddr (prog_waddr),
		.prog_wdata (prog_wdata),
		.prog_raddr (prog_raddr),
		.prog_rdata (prog_rdata),
		.stk_we     (stk_we),
		.stk_waddr  (stk_waddr),
		.stk_wdata  (stk_wdata),
		.stk_raddr  (stk_raddr),
		.stk_rdata  (stk_rdata),
		.tape_we    (tape_we),
		.tape_waddr (tape_waddr),
		.tape_wdata (tape_wdata),
		.tape_raddr (tape_raddr),
		.tape_rdata (tape_rdata)
	);

	// Command codes with their jump targets
	tli_ram #(.WIDTH(PW + 3), .DEPTH(PROG_DEPTH)) u_prog_ram (
		.clk   (clk),
		.we    (prog_we),
		.waddr (prog_waddr),
		.wdata (prog_wdata),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	// Positions of open brackets
	tli_ram #(.WIDTH(PW), .DEPTH(NEST_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Tape cells
	tli_ram #(.WIDTH(CELL_WIDTH), .DEPTH(TAPE_DEPTH)) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	// Result register toward the response channel
	tli_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.post_valid (post_valid),
		.post_ready (post_ready),
		.post_item  (post_item),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule
